// File: design/rgbxyz_pkg.sv
`default_nettype none
package rgbxyz_pkg;

  // field widths
  localparam int CH_W  = 16;
  localparam int LUM_W = 17;
  localparam int Q_W   = 32;
  localparam int LANES = 9;
  localparam int COLS  = 3;

  // packed stream widths
  localparam int IN_FIELDS_W = 6 * CH_W + LUM_W + 2 * CH_W;
  localparam int IN_W        = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_W       = LANES * Q_W;

  // datapath widths
  localparam int PZ_W     = CH_W + 2;
  localparam int CM_W     = CH_W + 1;
  localparam int PROD_W   = 2 * CH_W;
  localparam int T_W      = 2 * (CH_W + 1);
  localparam int V_W      = PROD_W + 4;
  localparam int VM_W     = V_W - 1;
  localparam int N_W      = PROD_W + 4;
  localparam int NM_W     = N_W - 1;
  localparam int NLO_W    = 18;
  localparam int NHI_W    = NM_W - NLO_W;
  localparam int CL_W     = CM_W + LUM_W;
  localparam int SCALE_SH = 8;
  localparam int NUM_W    = CL_W + NM_W + SCALE_SH;
  localparam int DEN_W    = VM_W + CH_W;

  // one in Q1.16
  localparam logic signed [PZ_W-1:0] ONE_Q16 = PZ_W'(65536);

  // saturation limits
  localparam logic [Q_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0] SAT_NEG = 32'h8000_0000;

  // one matrix entry under division
  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [Q_W-1:0]   lq;
    logic             neg;
    logic             ovf;
  } lane_t;

  // one item moving through the divider chain
  typedef struct packed {
    logic                    valid;
    logic                    bad;
    logic [DEN_W-1:0]        den;
    lane_t [LANES-1:0]       lanes;
  } div_t;

endpackage
`default_nettype wire

// File: design/rgbxyz_front.sv
`default_nettype none
module rgbxyz_front
  import rgbxyz_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [IN_W-1:0] in_data,
  output div_t                 dout
);

  function automatic logic signed [CH_W:0] sx(input logic [CH_W-1:0] v);
    return $signed({1'b0, v});
  endfunction

  // field unpack
  logic [CH_W-1:0]  xr, yr, xg, yg, xb, yb, xw, yw;
  logic [LUM_W-1:0] lum;
  assign xr  = in_data[0*CH_W +: CH_W];
  assign yr  = in_data[1*CH_W +: CH_W];
  assign xg  = in_data[2*CH_W +: CH_W];
  assign yg  = in_data[3*CH_W +: CH_W];
  assign xb  = in_data[4*CH_W +: CH_W];
  assign yb  = in_data[5*CH_W +: CH_W];
  assign lum = in_data[6*CH_W +: LUM_W];
  assign xw  = in_data[6*CH_W+LUM_W +: CH_W];
  assign yw  = in_data[7*CH_W+LUM_W +: CH_W];

  // stage a: cross products, weighted differences, entry magnitudes
  logic                     a_valid, a_bad;
  logic [PROD_W-1:0]        a_p [6];
  logic signed [T_W-1:0]    a_t [6];
  logic [CM_W-1:0]          a_cm [LANES];
  logic                     a_cneg [LANES];
  logic [LUM_W-1:0]         a_lum;
  logic [CH_W-1:0]          a_yw;

  logic [CH_W-1:0]          px [COLS];
  logic [CH_W-1:0]          py [COLS];
  logic signed [PZ_W-1:0]   pz [COLS];

  always_comb begin
    px[0] = xr; py[0] = yr;
    px[1] = xg; py[1] = yg;
    px[2] = xb; py[2] = yb;
    for (int j = 0; j < COLS; j++) begin
      pz[j] = ONE_Q16 - $signed({2'b0, px[j]}) - $signed({2'b0, py[j]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_bad  <= (yw == '0) || (yr == '0) || (yg == '0) || (yb == '0);
      a_p[0] <= yb * xg;
      a_p[1] <= yg * xb;
      a_p[2] <= xr * yb;
      a_p[3] <= yr * xb;
      a_p[4] <= xr * yg;
      a_p[5] <= yr * xg;
      a_t[0] <= (sx(yg) - sx(yb)) * sx(xw);
      a_t[1] <= (sx(xb) - sx(xg)) * sx(yw);
      a_t[2] <= (sx(yr) - sx(yb)) * sx(xw);
      a_t[3] <= (sx(xb) - sx(xr)) * sx(yw);
      a_t[4] <= (sx(yr) - sx(yg)) * sx(xw);
      a_t[5] <= (sx(xg) - sx(xr)) * sx(yw);
      for (int j = 0; j < COLS; j++) begin
        a_cm[3*j]     <= {1'b0, px[j]};
        a_cm[3*j+1]   <= {1'b0, py[j]};
        a_cm[3*j+2]   <= CM_W'(pz[j] < 0 ? -pz[j] : pz[j]);
        a_cneg[3*j]   <= 1'b0;
        a_cneg[3*j+1] <= 1'b0;
        a_cneg[3*j+2] <= pz[j] < 0;
      end
      a_lum <= lum;
      a_yw  <= yw;
    end
  end

  // stage b: divisor, per-column numerators, entry times luminance
  logic                   b_valid, b_bad;
  logic signed [V_W-1:0]  b_v;
  logic signed [N_W-1:0]  b_n [COLS];
  logic [CL_W-1:0]        b_cl [LANES];
  logic                   b_cneg [LANES];
  logic [CH_W-1:0]        b_yw;

  logic signed [V_W-1:0]  d [COLS];

  always_comb begin
    d[0] = V_W'($signed({1'b0, a_p[0]})) - V_W'($signed({1'b0, a_p[1]}));
    d[1] = V_W'($signed({1'b0, a_p[2]})) - V_W'($signed({1'b0, a_p[3]}));
    d[2] = V_W'($signed({1'b0, a_p[4]})) - V_W'($signed({1'b0, a_p[5]}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_bad  <= a_bad;
      b_v    <= d[2] - d[1] + d[0];
      b_n[0] <= N_W'(a_t[0]) + N_W'(a_t[1]) + N_W'(d[0]);
      b_n[1] <= -(N_W'(a_t[2]) + N_W'(a_t[3]) + N_W'(d[1]));
      b_n[2] <= N_W'(a_t[4]) + N_W'(a_t[5]) + N_W'(d[2]);
      for (int k = 0; k < LANES; k++) begin
        b_cl[k]   <= a_cm[k] * a_lum;
        b_cneg[k] <= a_cneg[k];
      end
      b_yw <= a_yw;
    end
  end

  // stage c: denominator and split numerator products
  logic                         c_valid, c_bad;
  logic [DEN_W-1:0]             c_den;
  logic [CL_W+NLO_W-1:0]        c_plo [LANES];
  logic [CL_W+NHI_W-1:0]        c_phi [LANES];
  logic                         c_neg [LANES];

  logic [VM_W-1:0]              vm;
  logic [NM_W-1:0]              nm [COLS];

  always_comb begin
    vm = VM_W'(b_v < 0 ? -b_v : b_v);
    for (int j = 0; j < COLS; j++) begin
      nm[j] = NM_W'(b_n[j] < 0 ? -b_n[j] : b_n[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_bad <= b_bad || (b_v == '0);
      c_den <= vm * b_yw;
      for (int j = 0; j < COLS; j++) begin
        for (int r = 0; r < COLS; r++) begin
          c_plo[3*j+r] <= b_cl[3*j+r] * nm[j][NLO_W-1:0];
          c_phi[3*j+r] <= b_cl[3*j+r] * nm[j][NM_W-1:NLO_W];
          c_neg[3*j+r] <= b_cneg[3*j+r] ^ (b_n[j] < 0) ^ (b_v < 0);
        end
      end
    end
  end

  // stage d: full numerator, overflow check, divider seed
  div_t            nxt;
  logic [NUM_W-1:0] num [LANES];

  always_comb begin
    nxt.valid = c_valid;
    nxt.bad   = c_bad;
    nxt.den   = c_den;
    for (int k = 0; k < LANES; k++) begin
      num[k] = NUM_W'((NUM_W'(c_plo[k]) + (NUM_W'(c_phi[k]) << NLO_W)) << SCALE_SH);
      nxt.lanes[k].ovf = DEN_W'(num[k][NUM_W-1:Q_W]) >= c_den;
      nxt.lanes[k].rem = DEN_W'(num[k][NUM_W-1:Q_W]);
      nxt.lanes[k].lq  = num[k][Q_W-1:0];
      nxt.lanes[k].neg = c_neg[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/rgbxyz_div_step.sv
`default_nettype none
module rgbxyz_div_step
  import rgbxyz_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  div_t      din,
  output div_t      dout
);

  // one restoring quotient bit per lane
  div_t               nxt;
  logic [DEN_W:0]     tmp [LANES];
  logic               ge  [LANES];

  always_comb begin
    nxt = din;
    for (int k = 0; k < LANES; k++) begin
      tmp[k] = {din.lanes[k].rem, din.lanes[k].lq[Q_W-1]};
      ge[k]  = tmp[k] >= {1'b0, din.den};
      nxt.lanes[k].rem = ge[k] ? DEN_W'(tmp[k] - {1'b0, din.den}) : DEN_W'(tmp[k]);
      nxt.lanes[k].lq  = {din.lanes[k].lq[Q_W-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/rgbxyz_round.sv
`default_nettype none
module rgbxyz_round
  import rgbxyz_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  div_t                  din,
  output logic                  out_valid,
  output logic [OUT_W-1:0]      out_data,
  output logic                  out_bad
);

  // round half away, saturate, apply sign; zero all entries of a bad item
  logic [OUT_W-1:0] data_next;
  logic             up   [LANES];
  logic [Q_W:0]     q33  [LANES];
  logic             sat  [LANES];
  logic [Q_W-1:0]   mag  [LANES];

  always_comb begin
    data_next = '0;
    for (int k = 0; k < LANES; k++) begin
      up[k]  = {din.lanes[k].rem, 1'b0} >= {1'b0, din.den};
      q33[k] = {1'b0, din.lanes[k].lq} + (Q_W+1)'(up[k]);
      if (din.lanes[k].neg) begin
        sat[k] = din.lanes[k].ovf || (q33[k] > {1'b0, SAT_NEG});
        mag[k] = sat[k] ? SAT_NEG : q33[k][Q_W-1:0];
        data_next[k*Q_W +: Q_W] = '0 - mag[k];
      end else begin
        sat[k] = din.lanes[k].ovf || (q33[k] > {1'b0, SAT_POS});
        mag[k] = sat[k] ? SAT_POS : q33[k][Q_W-1:0];
        data_next[k*Q_W +: Q_W] = mag[k];
      end
    end
    if (din.bad) begin
      data_next = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
      out_bad  <= din.bad;
    end
  end

endmodule
`default_nettype wire

// File: design/rgb_primaries_to_xyz_matrix.sv
// RGB-to-XYZ matrix from primary and white point chromaticities.
//
// Input stream (s_axis): one transaction carries the red, green and blue
// primary chromaticities and the white point (luminance, x, y).
// Output stream (m_axis): one transaction per input transaction, in order,
// carrying the nine matrix entries (signed Q8.24, saturated) in tdata and
// the bad_input flag in tuser; with bad_input set all entries are zero.
//
// Throughput is one transaction per cycle while no output stall holds the
// pipeline. From the accepting edge to m_axis_tvalid an item passes four
// front stages (products, sums, denominator and split numerator products,
// overflow check), one stage per quotient bit of the 32-stage restoring
// divider, and the rounding stage that is also the output register.
//
// Reset clears every stage valid; no transaction is in flight afterwards.
// When the receiver holds m_axis_tready low with a result waiting, the
// whole pipeline freezes and s_axis_tready drops; nothing is lost or
// repeated, and the output holds steady until taken.
`default_nettype none
module rgb_primaries_to_xyz_matrix
  import rgbxyz_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // red_x, red_y, green_x, green_y, blue_x, blue_y, white_lum, white_x, white_y
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // red_cx, red_cy, red_cz, green_cx, green_cy, green_cz, blue_cx, blue_cy, blue_cz
  output logic [OUT_W-1:0]      m_axis_tdata,
  // bad_input
  output logic                  m_axis_tuser
);

  // pipeline advances unless a result is stuck at the output
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  div_t chain [Q_W+1];

  rgbxyz_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_axis_tvalid),
    .in_data  (s_axis_tdata),
    .dout     (chain[0])
  );

  // divider chain, one quotient bit per stage
  for (genvar i = 0; i < Q_W; i++) begin : g_div
    rgbxyz_div_step u_step (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  rgbxyz_round u_round (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .din       (chain[Q_W]),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .out_bad   (m_axis_tuser)
  );

endmodule
`default_nettype wire

// File: design/rgbxyz_checker.sv
`default_nettype none
module rgbxyz_checker
  import rgbxyz_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             s_axis_tready,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [OUT_W-1:0] m_axis_tdata,
  input wire logic             m_axis_tuser
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled output changed");

  // a bad item carries an all-zero matrix
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("bad item with nonzero entries");

  // input side follows the output stall
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready not tied to output stall");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind rgb_primaries_to_xyz_matrix rgbxyz_checker u_chk (.*);
`default_nettype wire

// File: tb/sv/tb.sv
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rgbxyz_pkg::*;

  typedef struct {
    logic [15:0] rx, ry, gx, gy, bx, by;
    logic [16:0] lum;
    logic [15:0] wx, wy;
  } prim_t;

  typedef struct {
    logic [Q_W-1:0] ent [LANES];
    logic           bad;
  } matrix_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  // red_x, red_y, green_x, green_y, blue_x, blue_y, white_lum, white_x, white_y
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  // red_cx, red_cy, red_cz, green_cx, green_cy, green_cz, blue_cx, blue_cy, blue_cz
  logic [OUT_W-1:0] m_axis_tdata;
  // bad_input
  logic             m_axis_tuser;

  rgb_primaries_to_xyz_matrix uut (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  prim_t   pending_prims [$];
  matrix_t expected_cols [$];
  int      n_total = 0;
  int      n_sent = 0;
  int      errors = 0;
  int      cycles = 0;
  bit      took_item = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // one matrix entry: round(c*lum*n*256 / (v*wy)), ties away, saturated
  function automatic logic [31:0] scaled_quot(longint c, longint lum, longint n,
                                              longint v, longint wy);
    logic [127:0] num, den, q, r;
    bit neg;
    neg = ((c < 0) != (n < 0)) != (v < 0);
    num = 128'(c < 0 ? -c : c) * 128'(lum) * 128'(256) * 128'(n < 0 ? -n : n);
    den = 128'(v < 0 ? -v : v) * 128'(wy);
    if (num == 0) return 32'd0;
    q = num / den;
    r = num - q * den;
    if (r >= den - r) q = q + 1;
    if (neg) begin
      if (q > 128'h8000_0000) q = 128'h8000_0000;
      return 32'd0 - q[31:0];
    end
    if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
    return q[31:0];
  endfunction

  // matrix columns from primaries and white point
  function automatic matrix_t primaries_to_matrix(prim_t p);
    matrix_t m;
    longint xr, yr, xg, yg, xb, yb, lum, xw, yw, d1, d2, d3, v;
    longint n [3], px [3], py [3];
    xr = p.rx; yr = p.ry; xg = p.gx; yg = p.gy; xb = p.bx; yb = p.by;
    lum = p.lum; xw = p.wx; yw = p.wy;
    d1 = yb * xg - yg * xb;
    d2 = xr * yb - yr * xb;
    d3 = xr * yg - yr * xg;
    v = d3 - d2 + d1;
    for (int k = 0; k < LANES; k++) m.ent[k] = '0;
    m.bad = 1'b1;
    if (v == 0 || yw == 0 || yr == 0 || yg == 0 || yb == 0) return m;
    m.bad = 1'b0;
    n[0] = (yg - yb) * xw + (xb - xg) * yw + d1;
    n[1] = -((yr - yb) * xw + (xb - xr) * yw + d2);
    n[2] = (yr - yg) * xw + (xg - xr) * yw + d3;
    px[0] = xr; py[0] = yr;
    px[1] = xg; py[1] = yg;
    px[2] = xb; py[2] = yb;
    for (int k = 0; k < 3; k++) begin
      m.ent[3*k]   = scaled_quot(px[k], lum, n[k], v, yw);
      m.ent[3*k+1] = scaled_quot(py[k], lum, n[k], v, yw);
      m.ent[3*k+2] = scaled_quot(65536 - px[k] - py[k], lum, n[k], v, yw);
    end
    return m;
  endfunction

  function automatic logic [IN_W-1:0] pack_prims(prim_t p);
    return IN_W'({p.wy, p.wx, p.lum, p.by, p.bx, p.gy, p.gx, p.ry, p.rx});
  endfunction

  function automatic prim_t make_prims(int rx, int ry, int gx, int gy, int bx, int by,
                                       int lum, int wx, int wy);
    prim_t p;
    p.rx = 16'(rx); p.ry = 16'(ry); p.gx = 16'(gx); p.gy = 16'(gy);
    p.bx = 16'(bx); p.by = 16'(by);
    p.lum = 17'(lum); p.wx = 16'(wx); p.wy = 16'(wy);
    return p;
  endfunction

  function automatic logic [15:0] jitter(int base, int span);
    int val;
    val = base + $urandom_range(2 * span) - span;
    if (val < 1) val = 1;
    if (val > 65535) val = 65535;
    return val[15:0];
  endfunction

  // idling mix follows progress through the stimulus
  function automatic int idle_pct(bit rx_side);
    int ph;
    ph = (n_total == 0) ? 0 : (n_sent * 4) / n_total;
    case (ph)
      1: return rx_side ? 0 : 66;
      2: return rx_side ? 66 : 0;
      3: return 9;
      default: return 0;
    endcase
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // input transaction accepted: predict its matrix
  always @(posedge clk) begin
    took_item <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      expected_cols.push_back(primaries_to_matrix(pending_prims.pop_front()));
      n_sent <= n_sent + 1;
    end
  end

  // driver
  always @(negedge clk) begin
    logic nv;
    logic [IN_W-1:0] nd;
    nv = s_axis_tvalid;
    nd = s_axis_tdata;
    if (!rst) begin
      if (!s_axis_tvalid || took_item) begin
        nv = 1'b0;
        if (pending_prims.size() > 0 && $urandom_range(99) >= idle_pct(0)) begin
          nv = 1'b1;
          nd = pack_prims(pending_prims[0]);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= idle_pct(1));
    end
    s_axis_tvalid <= nv;
    s_axis_tdata <= nd;
  end

  // monitor
  always @(posedge clk) begin
    matrix_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_cols.size() == 0) begin
        $display("%0t: result with nothing expected, tuser=%0b", $time, m_axis_tuser);
        errors++;
      end else begin
        want = expected_cols.pop_front();
        if (m_axis_tuser !== want.bad) begin
          $display("%0t: bad_input expected %0b actual %0b", $time, want.bad, m_axis_tuser);
          errors++;
        end
        for (int k = 0; k < LANES; k++)
          if (m_axis_tdata[k*Q_W +: Q_W] !== want.ent[k]) begin
            $display("%0t: entry %0d expected %h actual %h", $time, k, want.ent[k],
                     m_axis_tdata[k*Q_W +: Q_W]);
            errors++;
          end
      end
    end
  end

  initial begin
    prim_t p;
    // directed: typical primaries, extremes, zero divisors, saturation
    pending_prims.push_back(make_prims(41943, 21627, 19661, 39322, 9830, 3932,
                                       65536, 20493, 21569));
    pending_prims.push_back(make_prims(41943, 21627, 19661, 39322, 9830, 3932,
                                       0, 20493, 21569));
    pending_prims.push_back(make_prims(41943, 21627, 19661, 39322, 9830, 3932,
                                       131071, 20493, 21569));
    pending_prims.push_back(make_prims(0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_prims.push_back(make_prims(41943, 0, 19661, 39322, 9830, 3932,
                                       65536, 20493, 21569));
    pending_prims.push_back(make_prims(41943, 21627, 19661, 0, 9830, 3932,
                                       65536, 20493, 21569));
    pending_prims.push_back(make_prims(41943, 21627, 19661, 39322, 9830, 0,
                                       65536, 20493, 21569));
    pending_prims.push_back(make_prims(41943, 21627, 19661, 39322, 9830, 3932,
                                       65536, 20493, 0));
    // collinear primaries give a zero determinant
    pending_prims.push_back(make_prims(20000, 20000, 20000, 20000, 20000, 20000,
                                       65536, 20493, 21569));
    pending_prims.push_back(make_prims(10000, 10000, 20000, 20000, 30000, 30000,
                                       65536, 20493, 21569));
    // near-degenerate triangle drives saturation
    pending_prims.push_back(make_prims(20000, 20000, 20001, 20000, 20000, 20001,
                                       131071, 65535, 1));
    pending_prims.push_back(make_prims(65535, 65535, 65535, 1, 1, 65535,
                                       131071, 65535, 65535));
    pending_prims.push_back(make_prims(65535, 1, 1, 65535, 1, 1, 65536, 1, 65535));
    pending_prims.push_back(make_prims(1, 1, 65535, 65535, 32768, 1,
                                       1, 65535, 1));
    // chromaticity sums above one, and swapped x and y
    pending_prims.push_back(make_prims(60000, 50000, 50000, 60000, 40000, 40000,
                                       65536, 30000, 30000));
    pending_prims.push_back(make_prims(21627, 41943, 39322, 19661, 3932, 9830,
                                       65536, 21569, 20493));
    // random: mostly plausible gamuts, the rest fully random fields
    for (int i = 0; i < 600; i++) begin
      if ($urandom_range(99) < 65) begin
        p.rx = jitter(41943, 12000); p.ry = jitter(21627, 12000);
        p.gx = jitter(19661, 12000); p.gy = jitter(39322, 12000);
        p.bx = jitter(9830, 8000);   p.by = jitter(3932, 3900);
        p.wx = jitter(20493, 8000);  p.wy = jitter(21569, 8000);
        p.lum = ($urandom_range(3) == 0) ? 17'($urandom_range(131071)) : 17'd65536;
      end else begin
        p.rx = 16'($urandom); p.ry = 16'($urandom); p.gx = 16'($urandom);
        p.gy = 16'($urandom); p.bx = 16'($urandom); p.by = 16'($urandom);
        p.wx = 16'($urandom); p.wy = 16'($urandom);
        p.lum = 17'($urandom);
        if ($urandom_range(9) == 0) p.gy = 16'd0;
      end
      pending_prims.push_back(p);
    end
    n_total = pending_prims.size();
    repeat (7) @(posedge clk);
    @(negedge clk) rst = 1'b0;
    wait (pending_prims.size() == 0 && !s_axis_tvalid);
    wait (expected_cols.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
